// ===== rtl/cubic_bspline_point_eval_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cubic B-spline point evaluator
// Shared property wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_POINT_EVAL_TOP_DEFINES_SVH
`define CUBIC_BSPLINE_POINT_EVAL_TOP_DEFINES_SVH

// check a property outside reset
`define CBSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define CBSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cbse_pkg.sv =====
// ----------------------------------------------------------------------------
// cbse_pkg
// Shared types, codes and helpers of the cubic B-spline point evaluator.
// ----------------------------------------------------------------------------
package cbse_pkg;

  localparam logic [1:0] MODE_KNOT = 2'd0;
  localparam logic [1:0] MODE_CTRL = 2'd1;
  localparam logic [1:0] MODE_EVAL = 2'd2;

  localparam int IDX_W = 7;   // knot index / span width
  localparam int NUM_W = 48;  // divider dividend and quotient width
  localparam int DEN_W = 33;  // divider divisor width

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // magnitude of a 33-bit difference known to stay below 2^32
  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? 33'(-v) : 33'(v);
    return t[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== rtl/cubic_bspline_point_eval_top.sv =====
// ----------------------------------------------------------------------------
// Cubic B-spline point evaluator: de Boor-Cox basis on one divider, one multiplier
// Write words: a new word every cycle while idle (in_stall low).
// Evaluate: up to six divides and the shared multiplier produce the point.
// Sync active-low reset clears control and sets last_point_index to 3; stores keep data.
// ----------------------------------------------------------------------------
module cubic_bspline_point_eval_top
  import cbse_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int DIMENSIONS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [6:0]         in_slot,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_write_value,
  input  logic signed [31:0] in_param_u,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic [6:0]         out_span_index,
  output logic               out_out_of_range
);

  // store geometry
  localparam int KD   = MAX_POINTS + 4;
  localparam int KAW  = $clog2(KD);
  localparam int KXW  = (KAW > IDX_W) ? KAW : IDX_W;
  localparam int CD   = MAX_POINTS * DIMENSIONS;
  localparam int CAW  = $clog2(CD);
  localparam int NMAX = (MAX_POINTS - 1 > 63) ? 63 : MAX_POINTS - 1;
  localparam int NAX  = (DIMENSIONS < 3) ? DIMENSIONS : 3;

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_TB     = 5'd1;
  localparam logic [4:0] S_TT     = 5'd2;
  localparam logic [4:0] S_CHK    = 5'd3;
  localparam logic [4:0] S_HI_RD  = 5'd4;
  localparam logic [4:0] S_HI_CK  = 5'd5;
  localparam logic [4:0] S_LO_RD  = 5'd6;
  localparam logic [4:0] S_LO_CK  = 5'd7;
  localparam logic [4:0] S_BS_RD  = 5'd8;
  localparam logic [4:0] S_BS_CK  = 5'd9;
  localparam logic [4:0] S_CLAMP  = 5'd10;
  localparam logic [4:0] S_R_RDR  = 5'd11;
  localparam logic [4:0] S_R_RDL  = 5'd12;
  localparam logic [4:0] S_R_DIV  = 5'd13;
  localparam logic [4:0] S_R_WDIV = 5'd14;
  localparam logic [4:0] S_M_LO   = 5'd15;
  localparam logic [4:0] S_M_HI   = 5'd16;
  localparam logic [4:0] S_M_FIN  = 5'd17;
  localparam logic [4:0] S_R_NEXT = 5'd18;
  localparam logic [4:0] S_S_RD   = 5'd19;
  localparam logic [4:0] S_S_MUL  = 5'd20;
  localparam logic [4:0] S_S_ACC  = 5'd21;
  localparam logic [4:0] S_DONE   = 5'd22;

  logic [4:0] state_r;
  logic [5:0] lpi_r;
  logic       out_valid_r;

  // evaluation context
  logic [IDX_W-1:0]  n_r, top_r, hi_r, lo_r, mid_r, span_r;
  logic signed [31:0] u_r, tb_r, tt_r, kr_r, saved_r;
  logic signed [31:0] m_r [4];
  logic signed [32:0] right_r, left_r;
  logic [2:0]        k_r;
  logic [1:0]        r_r, ax_r;
  logic [NUM_W-1:0]  qmag_r;
  logic              qneg_r, phase_r, psign_r;
  logic [55:0]       pl_r;
  logic signed [65:0] acc_r;
  logic signed [31:0] res_x_r, res_y_r, res_z_r;
  logic              oor_r;

  // result word
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic [IDX_W-1:0]  out_span_r;
  logic              out_oor_r;

  // stores
  logic signed [31:0] knot_mem [KD];
  logic signed [31:0] ctrl_mem [CD];
  logic signed [31:0] knot_q_r, ctrl_q_r;
  logic [KAW-1:0]    knot_ra;
  logic [KXW-1:0]    knot_ix;
  logic [IDX_W-1:0]  knot_idx;
  logic [CAW-1:0]    ctrl_ra, ctrl_wa;
  logic [KXW-1:0]    knot_wx;

  logic in_acc, out_load;

  // shared units
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;

  // recurrence datapath
  logic signed [32:0] d_cur;
  logic signed [47:0] term_val;
  logic [63:0]        p_sum;
  logic               p_sat;
  logic [46:0]        p_mag;
  logic               x_neg;
  logic signed [65:0] acc_nxt;
  logic signed [65:0] round_v;
  logic [IDX_W:0]     lo_p1;
  logic [IDX_W-1:0]   mid_c;
  logic [IDX_W-1:0]   span_cl;
  logic [IDX_W-1:0]   n_cl;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Knot read address: one read per cycle, data registered in knot_q_r in the next cycle.
  // ---------------------------------------------------------------------------
  assign mid_c = IDX_W'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  always_comb begin
    unique case (state_r)
      S_TT:    knot_idx = top_r;
      S_HI_RD: knot_idx = hi_r - 1'b1;
      S_LO_RD: knot_idx = lo_r + 1'b1;
      S_BS_RD: knot_idx = mid_c;
      S_R_RDR: knot_idx = span_r + 7'd1 + IDX_W'(r_r);
      S_R_RDL: knot_idx = span_r + 7'd2 + IDX_W'(r_r) - IDX_W'(k_r);
      default: knot_idx = '0;
    endcase
    knot_ix = KXW'(knot_idx);
    knot_ra = knot_ix[KAW-1:0];
    knot_wx = KXW'(in_slot);
  end

  // control point p axis a sits at p*DIMENSIONS + a
  assign ctrl_ra = CAW'(span_r - 7'd3 + IDX_W'(r_r)) * CAW'(DIMENSIONS) + CAW'(ax_r);
  assign ctrl_wa = CAW'(in_slot) * CAW'(DIMENSIONS) + CAW'(in_axis);

  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_KNOT && int'(in_slot) < KD) begin
      knot_mem[knot_wx[KAW-1:0]] <= in_write_value;
    end
    knot_q_r <= knot_mem[knot_ra];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_mode == MODE_CTRL && int'(in_slot) < MAX_POINTS &&
        int'(in_axis) < DIMENSIONS) begin
      ctrl_mem[ctrl_wa] <= in_write_value;
    end
    ctrl_q_r <= ctrl_mem[ctrl_ra];
  end

  // ---------------------------------------------------------------------------
  // Shared divider: q = trunc(m * 2^16 / d) on magnitudes, sign kept aside.
  // ---------------------------------------------------------------------------
  assign d_cur     = 33'(kr_r) - 33'(knot_q_r);
  assign div_start = (state_r == S_R_DIV) && (d_cur != '0);
  assign div_num   = {abs32(m_r[r_r]), 16'd0};
  assign div_den   = {1'b0, abs33(d_cur)};

  cbse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier: two 24-bit passes of q per basis term, one pass per
  // coordinate term.
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (state_r)
      S_M_LO: begin
        mul_a = phase_r ? abs33(left_r) : abs33(right_r);
        mul_b = {8'd0, qmag_r[23:0]};
      end
      S_M_HI: begin
        mul_a = phase_r ? abs33(left_r) : abs33(right_r);
        mul_b = {8'd0, qmag_r[47:24]};
      end
      S_S_MUL: begin
        mul_a = abs32(ctrl_q_r);
        mul_b = abs32(m_r[r_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cbse_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Scaled product (x*q)/2^16; magnitudes past 2^62 clip to 2^40.
  always_comb begin
    p_sum    = {1'b0, mul_p[38:0], 24'd0} + {8'd0, pl_r};
    p_sat    = (|mul_p[63:39]) || (p_sum > 64'h4000_0000_0000_0000);
    p_mag    = p_sat ? (47'd1 << 40) : p_sum[62:16];
    x_neg    = phase_r ? left_r[32] : right_r[32];
    term_val = (x_neg ^ qneg_r) ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
  end

  // Coordinate accumulation: exact sum of products with the Q30 basis, round half up.
  always_comb begin
    acc_nxt = acc_r + (psign_r ? -$signed({2'b00, mul_p}) : $signed({2'b00, mul_p}));
    round_v = (acc_nxt + 66'sd536870912) >>> 30;
  end

  always_comb begin
    lo_p1   = {1'b0, lo_r} + 1'b1;
    span_cl = span_r;
    if (span_cl < 7'd3) begin
      span_cl = 7'd3;
    end
    if (span_cl > n_r) begin
      span_cl = n_r;
    end
    n_cl = IDX_W'(lpi_r);
    if (n_cl < 7'd3) begin
      n_cl = 7'd3;
    end
    if (int'(n_cl) > NMAX) begin
      n_cl = IDX_W'(NMAX);
    end
  end

  // ---------------------------------------------------------------------------
  // Control: state, register, result valid.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lpi_r       <= 6'd3;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lpi_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE:   if (in_acc && in_mode == MODE_EVAL) state_r <= S_TB;
        S_TB:     state_r <= S_TT;
        S_TT:     state_r <= S_CHK;
        S_CHK: begin
          if (u_r < tb_r || u_r > knot_q_r) begin
            state_r <= S_DONE;
          end else if (u_r == knot_q_r) begin
            state_r <= S_CLAMP;
          end else begin
            state_r <= S_HI_RD;
          end
        end
        S_HI_RD:  state_r <= (hi_r == '0) ? S_LO_RD : S_HI_CK;
        S_HI_CK:  state_r <= (knot_q_r == tt_r) ? S_HI_RD : S_LO_RD;
        S_LO_RD:  state_r <= (lo_r >= top_r) ? S_BS_RD : S_LO_CK;
        S_LO_CK:  state_r <= (knot_q_r == tb_r) ? S_LO_RD : S_BS_RD;
        S_BS_RD:  state_r <= ({1'b0, hi_r} <= lo_p1) ? S_CLAMP : S_BS_CK;
        S_BS_CK:  state_r <= S_BS_RD;
        S_CLAMP:  state_r <= S_R_RDR;
        S_R_RDR:  state_r <= S_R_RDL;
        S_R_RDL:  state_r <= S_R_DIV;
        S_R_DIV:  state_r <= (d_cur == '0) ? S_R_NEXT : S_R_WDIV;
        S_R_WDIV: if (div_done) state_r <= S_M_LO;
        S_M_LO:   state_r <= S_M_HI;
        S_M_HI:   state_r <= S_M_FIN;
        S_M_FIN:  state_r <= phase_r ? S_R_NEXT : S_M_LO;
        S_R_NEXT: begin
          if (3'(r_r) == k_r - 3'd2 && k_r == 3'd4) begin
            state_r <= S_S_RD;
          end else begin
            state_r <= S_R_RDR;
          end
        end
        S_S_RD:   state_r <= S_S_MUL;
        S_S_MUL:  state_r <= S_S_ACC;
        S_S_ACC: begin
          if (r_r == 2'd3 && ax_r == 2'(NAX - 1)) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_S_RD;
          end
        end
        S_DONE:   if (out_load) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers: no reset, each loaded by the state that owns it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        // latch u and the clamped last point index for the new word
        u_r   <= in_param_u;
        n_r   <= n_cl;
        top_r <= n_cl + 7'd4;
      end
      S_TT: tb_r <= knot_q_r;
      S_CHK: begin
        tt_r    <= knot_q_r;
        hi_r    <= top_r;
        // out of range reports span zero
        span_r  <= (u_r < tb_r || u_r > knot_q_r) ? '0 : n_r;
        oor_r   <= (u_r < tb_r || u_r > knot_q_r);
        res_x_r <= '0;
        res_y_r <= '0;
        res_z_r <= '0;
      end
      S_HI_RD: if (hi_r == '0) lo_r <= '0;
      S_HI_CK: begin
        // drop repeated top knots from the search window
        if (knot_q_r == tt_r) begin
          hi_r <= hi_r - 1'b1;
        end else begin
          lo_r <= '0;
        end
      end
      S_LO_CK: if (knot_q_r == tb_r) lo_r <= lo_r + 1'b1;
      S_BS_RD: begin
        mid_r  <= mid_c;
        span_r <= lo_r;
      end
      S_BS_CK: begin
        if (u_r < knot_q_r) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r;
        end
      end
      S_CLAMP: begin
        span_r  <= span_cl;
        m_r[0]  <= ONE_Q30;
        saved_r <= '0;
        k_r     <= 3'd2;
        r_r     <= 2'd0;
        ax_r    <= 2'd0;
        acc_r   <= '0;
      end
      S_R_RDL: kr_r <= knot_q_r;
      S_R_DIV: begin
        right_r <= 33'(kr_r) - 33'(u_r);
        left_r  <= 33'(u_r) - 33'(knot_q_r);
        qneg_r  <= m_r[r_r][31] ^ d_cur[32];
        phase_r <= 1'b0;
        if (d_cur == '0) begin
          m_r[r_r] <= saved_r;
          saved_r  <= '0;
        end
      end
      S_R_WDIV: qmag_r <= div_quo;
      S_M_HI:   pl_r   <= mul_p[55:0];
      S_M_FIN: begin
        if (phase_r) begin
          saved_r <= sat32(66'(term_val));
        end else begin
          m_r[r_r] <= sat32(66'(saved_r) + 66'(term_val));
          phase_r  <= 1'b1;
        end
      end
      S_R_NEXT: begin
        if (3'(r_r) == k_r - 3'd2) begin
          m_r[2'(k_r - 3'd1)] <= saved_r;
          k_r     <= k_r + 3'd1;
          r_r     <= 2'd0;
          saved_r <= '0;
        end else begin
          r_r <= r_r + 2'd1;
        end
      end
      S_S_MUL: psign_r <= ctrl_q_r[31] ^ m_r[r_r][31];
      S_S_ACC: begin
        if (r_r == 2'd3) begin
          unique case (ax_r)
            2'd0:    res_x_r <= sat32(round_v);
            2'd1:    res_y_r <= sat32(round_v);
            default: res_z_r <= sat32(round_v);
          endcase
          acc_r <= '0;
          r_r   <= 2'd0;
          ax_r  <= ax_r + 2'd1;
        end else begin
          acc_r <= acc_nxt;
          r_r   <= r_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // result word: hold while stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_z_r    <= res_z_r;
      out_span_r <= span_r;
      out_oor_r  <= oor_r;
    end
  end

  assign out_point_x      = out_x_r;
  assign out_point_y      = out_y_r;
  assign out_point_z      = out_z_r;
  assign out_span_index   = out_span_r;
  assign out_out_of_range = out_oor_r;

endmodule

// ===== rtl/cbse_div.sv =====
// ----------------------------------------------------------------------------
// cbse_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbse_div
  import cbse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/cbse_mul.sv =====
// ----------------------------------------------------------------------------
// cbse_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cbse_mul
  import cbse_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

  assign p = p_r;

endmodule

// ===== rtl/cbse_checker.sv =====
// ----------------------------------------------------------------------------
// cbse_checker
// Port-level checks of the cubic B-spline point evaluator.
// ----------------------------------------------------------------------------
`include "cubic_bspline_point_eval_top_defines.svh"

module cbse_checker
  import cbse_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_point_x,
  input logic signed [31:0] out_point_y,
  input logic signed [31:0] out_point_z,
  input logic [6:0]         out_span_index,
  input logic               out_out_of_range
);

  // every field of an out of range word is zero
  logic oor_zeroed;
  assign oor_zeroed = (out_point_x == 0) && (out_point_y == 0) && (out_point_z == 0) &&
                      (out_span_index == 0);

  `CBSE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result word dropped")
  `CBSE_ASSERT(a_oor_zero, out_valid && out_out_of_range |-> oor_zeroed, "oor word not zero")
  `CBSE_ASSERT(a_span_low, out_valid && !out_out_of_range |-> out_span_index >= 7'd3, "span low")
  `CBSE_ASSERT(a_eval_busy, in_valid && !in_stall && in_mode == MODE_EVAL |=> in_stall, "no stall")
  `CBSE_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind cubic_bspline_point_eval_top cbse_checker u_cbse_checker (.*);
